FILE: rtl/core/hrf_pkg.sv
`default_nettype none

package hrf_pkg;

    // default geometry of a report
    localparam int REPORT_BYTES_DEF      = 64;
    localparam int FIRST_CHUNK_BYTES_DEF = 52;
    localparam int LATER_CHUNK_BYTES_DEF = 61;
    localparam int MAX_REPORTS_DEF       = 5;

    // header sizes in bytes
    localparam int FIRST_HDR_BYTES = 11;
    localparam int LATER_HDR_BYTES = 3;

    localparam int SEQ_W  = 4;
    localparam int CLEN_W = 6;
    localparam int LEN_W  = 9;

    // fixed header contents
    localparam logic [7:0] REPORT_ID      = 8'h01;
    localparam logic [7:0] PROTO_VERSION  = 8'h00;
    localparam logic [7:0] PROTO_HDR_LEN  = 8'h08;
    localparam logic [7:0] PROTO_TUNNEL   = 8'h01;
    localparam logic [7:0] EMI_CEMI       = 8'h03;
    localparam logic [7:0] MANUF_BYTE     = 8'h00;
    localparam logic [7:0] PAD_BYTE       = 8'h00;

    // packet info type bits
    localparam int TYPE_START_BIT   = 0;
    localparam int TYPE_END_BIT     = 1;
    localparam int TYPE_PARTIAL_BIT = 2;

    localparam int QUEUE_DEPTH = 2;

    // one classified body byte, front to back
    typedef struct packed {
        logic [7:0]        data;
        logic              first;
        logic [7:0]        info;
        logic [CLEN_W-1:0] clen;
        logic [LEN_W-1:0]  frame_len;
        logic [7:0]        protocol;
        logic [7:0]        emi;
        logic              chunk_end;
        logic              frame_end;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/hid_report_fragmenter.sv
// Cuts a transfer frame, fed one body byte per push, into 64-byte HID reports
// that leave one byte per pop. The first report carries the report id, packet
// info, body length and the 8-byte protocol header, later ones a 3-byte header;
// each is zero-padded to the report size, and run_last marks the last byte a
// pushed byte causes. The input side classifies a byte combinationally and parks
// it in a two-entry command queue; the output side emits one report byte per
// cycle into an output register while a command waits and that register is
// free or popped; a pushed byte yields one report byte (plain body byte) up to
// a whole report (header, byte, padding), and the output side sets the rate.
// frame_length, protocol_id and service_id are sampled on the first byte of a
// frame; a zero length counts as one and lengths beyond five reports are cut.
`default_nettype none

module hid_report_fragmenter #(
    parameter int REPORT_BYTES      = hrf_pkg::REPORT_BYTES_DEF,
    parameter int FIRST_CHUNK_BYTES = hrf_pkg::FIRST_CHUNK_BYTES_DEF,
    parameter int LATER_CHUNK_BYTES = hrf_pkg::LATER_CHUNK_BYTES_DEF,
    parameter int MAX_REPORTS       = hrf_pkg::MAX_REPORTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic [8:0] i_frame_length,
    input  wire logic [7:0] i_protocol_id,
    input  wire logic [7:0] i_service_id,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_report_byte,
    output logic            o_run_last,
    output logic            o_report_last,
    output logic            o_frame_last
);

    hrf_pkg::t_cmd cmd_in, cmd_head;
    logic          take, q_empty, q_pop;

    assign take = push && !full;

    hrf_front #(
        .REPORT_BYTES      (REPORT_BYTES),
        .FIRST_CHUNK_BYTES (FIRST_CHUNK_BYTES),
        .LATER_CHUNK_BYTES (LATER_CHUNK_BYTES),
        .MAX_REPORTS       (MAX_REPORTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_payload_byte (i_payload_byte),
        .i_frame_length (i_frame_length),
        .i_protocol_id  (i_protocol_id),
        .i_service_id   (i_service_id),
        .o_cmd          (cmd_in)
    );

    hrf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (cmd_head)
    );

    hrf_back #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (q_empty),
        .i_cmd         (cmd_head),
        .o_cmd_pop     (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_report_byte (o_report_byte),
        .o_run_last    (o_run_last),
        .o_report_last (o_report_last),
        .o_frame_last  (o_frame_last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hrf_front.sv
`default_nettype none

module hrf_front #(
    parameter int REPORT_BYTES      = hrf_pkg::REPORT_BYTES_DEF,
    parameter int FIRST_CHUNK_BYTES = hrf_pkg::FIRST_CHUNK_BYTES_DEF,
    parameter int LATER_CHUNK_BYTES = hrf_pkg::LATER_CHUNK_BYTES_DEF,
    parameter int MAX_REPORTS       = hrf_pkg::MAX_REPORTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire logic [7:0]                    i_payload_byte,
    input  wire logic [hrf_pkg::LEN_W-1:0]     i_frame_length,
    input  wire logic [7:0]                    i_protocol_id,
    input  wire logic [7:0]                    i_service_id,
    output hrf_pkg::t_cmd                      o_cmd
);

    localparam int FIRST_ROOM = REPORT_BYTES - hrf_pkg::FIRST_HDR_BYTES;
    localparam int LATER_ROOM = REPORT_BYTES - hrf_pkg::LATER_HDR_BYTES;
    localparam int FIRST_CAP  = (FIRST_CHUNK_BYTES < FIRST_ROOM) ? FIRST_CHUNK_BYTES : FIRST_ROOM;
    localparam int LATER_CAP  = (LATER_CHUNK_BYTES < LATER_ROOM) ? LATER_CHUNK_BYTES : LATER_ROOM;
    localparam int CAPACITY   = FIRST_CAP + (MAX_REPORTS - 1) * LATER_CAP;

    localparam int LW = hrf_pkg::LEN_W;
    localparam int CW = hrf_pkg::CLEN_W;
    localparam int SW = hrf_pkg::SEQ_W;

    logic [LW-1:0] r_taken, n_taken;
    logic [LW-1:0] r_held;
    logic [SW-1:0] r_seq, n_seq;
    logic [CW-1:0] r_cpos, n_cpos;
    logic [7:0]    r_proto;
    logic [7:0]    r_service;

    logic          fresh;
    logic [LW-1:0] len_in, len_sat, held;
    logic [SW-1:0] seq;
    logic [CW-1:0] cpos, cpos_inc, cap, clen;
    logic [7:0]    proto, service;
    logic [LW-1:0] start, rem;
    logic          first, last_rep, chunk_end;
    logic [2:0]    ptype;

    always_comb begin
        fresh    = (r_taken == '0);
        len_in   = (i_frame_length == '0) ? LW'(1) : i_frame_length;
        len_sat  = (32'(len_in) > CAPACITY) ? LW'(CAPACITY) : len_in;
        held     = fresh ? len_sat : r_held;
        seq      = fresh ? SW'(1) : r_seq;
        cpos     = fresh ? '0 : r_cpos;
        proto    = fresh ? i_protocol_id : r_proto;
        service  = fresh ? i_service_id : r_service;

        first    = (seq == SW'(1));
        cap      = first ? CW'(FIRST_CAP) : CW'(LATER_CAP);
        start    = r_taken - LW'(cpos);
        rem      = held - start;
        last_rep = (rem <= LW'(cap));
        clen     = last_rep ? rem[CW-1:0] : cap;
        cpos_inc = cpos + CW'(1);
        chunk_end = (cpos_inc >= clen);

        ptype = '0;
        ptype[hrf_pkg::TYPE_START_BIT]   = first;
        ptype[hrf_pkg::TYPE_END_BIT]     = last_rep;
        ptype[hrf_pkg::TYPE_PARTIAL_BIT] = (32'(held) > FIRST_CAP);

        o_cmd.data      = i_payload_byte;
        o_cmd.first     = first;
        o_cmd.info      = {seq, 1'b0, ptype};
        o_cmd.clen      = clen;
        o_cmd.frame_len = held;
        o_cmd.protocol  = proto;
        o_cmd.emi       = (proto == hrf_pkg::PROTO_TUNNEL) ? hrf_pkg::EMI_CEMI : service;
        o_cmd.chunk_end = chunk_end;
        o_cmd.frame_end = last_rep;

        n_taken = r_taken + LW'(1);
        n_seq   = seq;
        n_cpos  = cpos_inc;
        if (chunk_end) begin
            n_cpos = '0;
            if (last_rep) begin
                n_taken = '0;
                n_seq   = SW'(1);
            end else begin
                n_seq = seq + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken   <= '0;
            r_held    <= '0;
            r_seq     <= SW'(1);
            r_cpos    <= '0;
            r_proto   <= '0;
            r_service <= '0;
        end else if (i_take) begin
            r_taken   <= n_taken;
            r_held    <= held;
            r_seq     <= n_seq;
            r_cpos    <= n_cpos;
            r_proto   <= proto;
            r_service <= service;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hrf_cmd_queue.sv
`default_nettype none

module hrf_cmd_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire hrf_pkg::t_cmd i_cmd,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_empty,
    output hrf_pkg::t_cmd o_head
);

    localparam int D  = hrf_pkg::QUEUE_DEPTH;
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CNTW = $clog2(D + 1);

    hrf_pkg::t_cmd r_mem [D];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CNTW'(D));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(D - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(D - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CNTW'(do_push) - CNTW'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hrf_back.sv
`default_nettype none

module hrf_back #(
    parameter int REPORT_BYTES = hrf_pkg::REPORT_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_empty,
    input  wire hrf_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_report_byte,
    output logic               o_run_last,
    output logic               o_report_last,
    output logic               o_frame_last
);

    localparam int PW = $clog2(REPORT_BYTES);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_pad, n_pad;
    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_run_last, r_rep_last, r_frm_last;

    logic          advance;
    logic          at_end, in_hdr;
    logic [PW-1:0] hdr_len;
    logic [7:0]    hdr_byte, byte_n;
    logic          run_n, rep_n, frm_n;

    assign advance = !i_cmd_empty && (!r_ov || i_pop);
    assign at_end  = (r_pos == PW'(REPORT_BYTES - 1));
    assign hdr_len = i_cmd.first ? PW'(hrf_pkg::FIRST_HDR_BYTES)
                                 : PW'(hrf_pkg::LATER_HDR_BYTES);
    assign in_hdr  = !r_pad && (r_pos < hdr_len);

    always_comb begin
        hdr_byte = hrf_pkg::PAD_BYTE;
        unique case (r_pos[3:0])
            4'd0: hdr_byte = hrf_pkg::REPORT_ID;
            4'd1: hdr_byte = i_cmd.info;
            4'd2: hdr_byte = i_cmd.first ? hrf_pkg::PROTO_HDR_LEN + 8'(i_cmd.clen)
                                         : 8'(i_cmd.clen);
            4'd3: hdr_byte = hrf_pkg::PROTO_VERSION;
            4'd4: hdr_byte = hrf_pkg::PROTO_HDR_LEN;
            4'd5: hdr_byte = {7'd0, i_cmd.frame_len[8]};
            4'd6: hdr_byte = i_cmd.frame_len[7:0];
            4'd7: hdr_byte = i_cmd.protocol;
            4'd8: hdr_byte = i_cmd.emi;
            4'd9: hdr_byte = hrf_pkg::MANUF_BYTE;
            4'd10: hdr_byte = hrf_pkg::MANUF_BYTE;
            default: hdr_byte = hrf_pkg::PAD_BYTE;
        endcase
    end

    always_comb begin
        byte_n    = hrf_pkg::PAD_BYTE;
        run_n     = 1'b0;
        rep_n     = 1'b0;
        frm_n     = 1'b0;
        o_cmd_pop = 1'b0;
        n_pos     = r_pos + PW'(1);
        n_pad     = r_pad;
        if (in_hdr) begin
            byte_n = hdr_byte;
        end else if (!r_pad) begin
            // the body byte itself
            byte_n = i_cmd.data;
            if (i_cmd.chunk_end && !at_end) begin
                n_pad = 1'b1;
            end else begin
                run_n     = 1'b1;
                o_cmd_pop = advance;
                if (i_cmd.chunk_end) begin
                    rep_n = 1'b1;
                    frm_n = i_cmd.frame_end;
                end
            end
        end else if (at_end) begin
            run_n     = 1'b1;
            rep_n     = 1'b1;
            frm_n     = i_cmd.frame_end;
            n_pad     = 1'b0;
            o_cmd_pop = advance;
        end
        if (rep_n) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_pad <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (advance) begin
                r_pos <= n_pos;
                r_pad <= n_pad;
                r_ov  <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte     <= byte_n;
            r_run_last <= run_n;
            r_rep_last <= rep_n;
            r_frm_last <= frm_n;
        end
    end

    assign o_empty       = !r_ov;
    assign o_report_byte = r_byte;
    assign o_run_last    = r_run_last;
    assign o_report_last = r_rep_last;
    assign o_frame_last  = r_frm_last;

endmodule

`default_nettype wire

FILE: test/hid_report_fragmenter_tb.sv
`default_nettype none

module hid_report_fragmenter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIRST_CAP =
        (hrf_pkg::FIRST_CHUNK_BYTES_DEF <
         hrf_pkg::REPORT_BYTES_DEF - hrf_pkg::FIRST_HDR_BYTES) ?
        hrf_pkg::FIRST_CHUNK_BYTES_DEF :
        hrf_pkg::REPORT_BYTES_DEF - hrf_pkg::FIRST_HDR_BYTES;
    localparam int LATER_CAP =
        (hrf_pkg::LATER_CHUNK_BYTES_DEF <
         hrf_pkg::REPORT_BYTES_DEF - hrf_pkg::LATER_HDR_BYTES) ?
        hrf_pkg::LATER_CHUNK_BYTES_DEF :
        hrf_pkg::REPORT_BYTES_DEF - hrf_pkg::LATER_HDR_BYTES;
    localparam int FRAME_CAP = FIRST_CAP + (hrf_pkg::MAX_REPORTS_DEF - 1) * LATER_CAP;

    localparam logic [7:0] PROTO_BAS = 8'h0F;
    localparam int RANDOM_ITEMS = 500;
    localparam int STALL_AT_BEAT = 600;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       report_last;
        logic       frame_last;
    } t_report_beat;

    typedef struct {
        logic [7:0] payload;
        logic [8:0] flen;
        logic [7:0] proto;
        logic [7:0] svc;
        int         gap;
        bit         drain;
    } t_body_byte;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_payload_byte = '0;
    logic [8:0] i_frame_length = '0;
    logic [7:0] i_protocol_id = '0;
    logic [7:0] i_service_id = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_report_byte;
    logic       o_run_last;
    logic       o_report_last;
    logic       o_frame_last;

    t_body_byte   pending_bytes[$];
    t_body_byte   cur_byte;
    t_report_beat beats_due[$];

    // predictor state
    int         fr_taken = 0;
    int         fr_len = 0;
    logic [3:0] fr_seq = 4'd1;
    int         chunk_pos = 0;
    logic [7:0] fr_proto = '0;
    logic [7:0] fr_svc = '0;

    int mismatch_count = 0;
    int beats_seen = 0;
    int tx_hold = 0;
    int rx_hold = 0;
    bit rx_fast = 1'b0;

    hid_report_fragmenter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_payload_byte (i_payload_byte),
        .i_frame_length (i_frame_length),
        .i_protocol_id  (i_protocol_id),
        .i_service_id   (i_service_id),
        .empty          (empty),
        .pop            (pop),
        .o_report_byte  (o_report_byte),
        .o_run_last     (o_run_last),
        .o_report_last  (o_report_last),
        .o_frame_last   (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_beat(input logic [7:0] data);
        beats_due.push_back({data, 1'b0, 1'b0, 1'b0});
    endfunction

    // works out the report bytes one body byte releases
    task automatic predict_report_bytes(input t_body_byte b);
        int len;
        int hdr;
        int cap;
        int start;
        int clen;
        bit first;
        bit last_rpt;
        logic [7:0] info;
        if (fr_taken == 0) begin
            len = (b.flen == 0) ? 1 : int'(b.flen);
            fr_len = (len > FRAME_CAP) ? FRAME_CAP : len;
            fr_proto = b.proto;
            fr_svc = b.svc;
            fr_seq = 4'd1;
            chunk_pos = 0;
        end
        first = (fr_seq == 4'd1);
        hdr = first ? hrf_pkg::FIRST_HDR_BYTES : hrf_pkg::LATER_HDR_BYTES;
        cap = first ? FIRST_CAP : LATER_CAP;
        start = fr_taken - chunk_pos;
        clen = (fr_len - start < cap) ? fr_len - start : cap;
        last_rpt = (start + clen >= fr_len);
        if (chunk_pos == 0) begin
            info = {fr_seq, 4'h0};
            if (first) info[hrf_pkg::TYPE_START_BIT] = 1'b1;
            if (fr_len > FIRST_CAP) info[hrf_pkg::TYPE_PARTIAL_BIT] = 1'b1;
            if (last_rpt) info[hrf_pkg::TYPE_END_BIT] = 1'b1;
            add_beat(hrf_pkg::REPORT_ID);
            add_beat(info);
            if (first) begin
                add_beat(8'(8 + clen));
                add_beat(hrf_pkg::PROTO_VERSION);
                add_beat(hrf_pkg::PROTO_HDR_LEN);
                add_beat(8'(fr_len >> 8));
                add_beat(8'(fr_len));
                add_beat(fr_proto);
                add_beat((fr_proto == hrf_pkg::PROTO_TUNNEL) ? hrf_pkg::EMI_CEMI : fr_svc);
                add_beat(hrf_pkg::MANUF_BYTE);
                add_beat(hrf_pkg::MANUF_BYTE);
            end else begin
                add_beat(8'(clen));
            end
        end
        add_beat(b.payload);
        chunk_pos++;
        fr_taken++;
        if (chunk_pos >= clen) begin
            for (int pos = hdr + chunk_pos; pos < hrf_pkg::REPORT_BYTES_DEF; pos++) begin
                add_beat(hrf_pkg::PAD_BYTE);
            end
            beats_due[beats_due.size() - 1].report_last = 1'b1;
            if (last_rpt) begin
                beats_due[beats_due.size() - 1].frame_last = 1'b1;
                fr_taken = 0;
                fr_seq = 4'd1;
            end else begin
                fr_seq = fr_seq + 4'd1;
            end
            chunk_pos = 0;
        end
        beats_due[beats_due.size() - 1].run_last = 1'b1;
    endtask

    task automatic queue_body_byte(input logic [7:0] payload, input logic [8:0] flen,
                                   input logic [7:0] proto, input logic [7:0] svc,
                                   input int gap, input bit drain);
        t_body_byte b;
        b.payload = payload;
        b.flen = flen;
        b.proto = proto;
        b.svc = svc;
        b.gap = gap;
        b.drain = drain;
        pending_bytes.push_back(b);
    endtask

    task automatic queue_random_frame(input int len_field, input bit drain_first);
        int count;
        int pick;
        bit fast;
        logic [7:0] proto;
        count = (len_field == 0) ? 1 : ((len_field > FRAME_CAP) ? FRAME_CAP : len_field);
        fast = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 2);
            proto = (pick == 0) ? hrf_pkg::PROTO_TUNNEL :
                    ((pick == 1) ? PROTO_BAS : 8'($urandom));
            if (k != 0) proto = 8'($urandom);
            // frame_length only counts on the opening byte, noise elsewhere
            queue_body_byte(8'($urandom), (k == 0) ? 9'(len_field) : 9'($urandom),
                            proto, 8'($urandom), fast ? 0 : $urandom_range(0, 9),
                            drain_first && k == 0);
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        logic next_push;
        if (i_rst_n) begin
            next_push = push;
            if (push && !full) begin
                predict_report_bytes(cur_byte);
                next_push = 1'b0;
            end
            if (!next_push) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                end else if (pending_bytes.size() > 0 &&
                             !(pending_bytes[0].drain && beats_due.size() != 0)) begin
                    cur_byte = pending_bytes.pop_front();
                    tx_hold = cur_byte.gap;
                    i_payload_byte <= cur_byte.payload;
                    i_frame_length <= cur_byte.flen;
                    i_protocol_id <= cur_byte.proto;
                    i_service_id <= cur_byte.svc;
                    next_push = 1'b1;
                end
            end
            push <= next_push;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_report_beat got;
        t_report_beat want;
        logic next_pop;
        if (i_rst_n) begin
            next_pop = pop;
            if (pop && !empty) begin
                got = {o_report_byte, o_run_last, o_report_last, o_frame_last};
                beats_seen++;
                if (beats_due.size() == 0) begin
                    $display({"%0t: unexpected report beat: expected none ",
                              "actual byte=%02h run=%0b rpt=%0b frm=%0b"},
                             $realtime, got.data, got.run_last, got.report_last,
                             got.frame_last);
                    mismatch_count++;
                end else begin
                    want = beats_due.pop_front();
                    if (got !== want) begin
                        $display({"%0t: report beat mismatch: ",
                                  "expected byte=%02h run=%0b rpt=%0b frm=%0b ",
                                  "actual byte=%02h run=%0b rpt=%0b frm=%0b"},
                                 $realtime, want.data, want.run_last, want.report_last,
                                 want.frame_last, got.data, got.run_last, got.report_last,
                                 got.frame_last);
                        mismatch_count++;
                    end
                end
                if (beats_seen % 128 == 0) rx_fast = ($urandom_range(0, 2) == 0);
                // one long hold-off so the input side backs up
                if (beats_seen == STALL_AT_BEAT) rx_hold = STALL_CYCLES;
                else rx_hold = rx_fast ? 0 : $urandom_range(0, 9);
                next_pop = (rx_hold == 0);
            end else if (!pop) begin
                if (rx_hold > 0) rx_hold--;
                next_pop = (rx_hold == 0);
            end
            pop <= next_pop;
        end
    end

    initial begin
        int frame_idx;
        int len_field;
        int r;
        int bnd;
        int room;

        // zero length counts as one byte, tunneling replaces service id
        queue_body_byte(8'h00, 9'd0, hrf_pkg::PROTO_TUNNEL, 8'h55, 0, 1'b0);
        queue_body_byte(8'hFF, 9'd1, PROTO_BAS, 8'hFF, 3, 1'b0);
        queue_body_byte(8'h5A, 9'd1, 8'h00, 8'h00, 0, 1'b0);
        queue_body_byte(8'hA5, 9'd1, 8'hFF, 8'hAA, 9, 1'b0);
        queue_body_byte(8'h00, 9'd3, hrf_pkg::PROTO_TUNNEL, 8'hFF, 0, 1'b0);
        queue_body_byte(8'hFF, 9'd511, 8'hFF, 8'h00, 0, 1'b0);
        queue_body_byte(8'hA5, 9'd256, 8'h00, 8'hFF, 2, 1'b0);
        queue_body_byte(8'h01, 9'd2, 8'hFE, 8'h01, 0, 1'b0);
        queue_body_byte(8'h80, 9'h1FF, 8'h01, 8'h80, 0, 1'b0);

        // random frames; first one waits until the block has drained
        frame_idx = 0;
        while (pending_bytes.size() < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            bnd = FIRST_CAP + $urandom_range(0, hrf_pkg::MAX_REPORTS_DEF - 1) * LATER_CAP;
            if (frame_idx == 2 || r == 9) len_field = $urandom_range(FRAME_CAP + 1, 511);
            else if (r <= 3) len_field = $urandom_range(0, 20);
            else if (r <= 6) len_field = bnd + $urandom_range(0, 2) - 1;
            else len_field = $urandom_range(21, FRAME_CAP);
            // keep the total close to the item budget
            room = RANDOM_ITEMS + 20 - pending_bytes.size();
            if (len_field > room) len_field = room;
            queue_random_frame(len_field, frame_idx == 0 || $urandom_range(0, 9) == 0);
            frame_idx++;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || push) @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("hid_report_fragmenter_tb passed");
        end else begin
            $display("hid_report_fragmenter_tb failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("hid_report_fragmenter_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
